### src/rmvs_pkg.sv
// Shared types and constants for the running mean/variance statistics block.
// No dependencies; imported by every module under src except rmvs_ram.
`timescale 1ns / 1ps
`default_nettype none

package rmvs_pkg;

    // Default number of per-channel accumulators
    localparam int NumChannelsDef = 16;

    // Field widths
    localparam int ChW    = 4;
    localparam int SmpW   = 16;
    localparam int CntW   = 24;
    localparam int SumW   = 40;
    localparam int SqW    = 55;
    localparam int VarW   = 32;
    localparam int StdW   = 16;
    localparam int AccW   = CntW + SumW + SqW;

    // Arithmetic widths in the back end
    localparam int ProdW  = 80;
    localparam int DivW   = 48;
    localparam int StepW  = 7;

    localparam logic [CntW-1:0] CountMax = {CntW{1'b1}};

    // Queue between front and back
    localparam int QDepth = 2;

    // One accumulator update handed from the front to the back
    typedef struct packed {
        logic                   ok;      // channel present
        logic                   sat;     // count was full, sample dropped
        logic [CntW-1:0]        count;
        logic signed [SumW-1:0] sum;
        logic [SqW-1:0]         sumsq;
    } t_job;

    // Front state machine
    typedef enum logic [2:0] {
        F_CLEAR  = 3'b001,
        F_IDLE   = 3'b010,
        F_UPDATE = 3'b100
    } t_front_state;

    // Back sequencer
    typedef enum logic [7:0] {
        B_IDLE = 8'b0000_0001,
        B_DIVM = 8'b0000_0010,
        B_MULA = 8'b0000_0100,
        B_MULB = 8'b0000_1000,
        B_MULD = 8'b0001_0000,
        B_DIVV = 8'b0010_0000,
        B_SQRT = 8'b0100_0000,
        B_DONE = 8'b1000_0000
    } t_back_state;

endpackage

`default_nettype wire

### src/running_mean_variance_stats.sv
// Top level of the per-channel running mean / variance / std-dev block.
// Depends on rmvs_pkg, rmvs_front, rmvs_fifo, rmvs_back (and rmvs_ram).
//
//   channel   direction  handshake           payload
//   sample    in         i_valid / o_stall   i_channel, i_sample
//   result    out        o_valid / i_stall   o_count, o_mean, o_variance,
//                                            o_std_dev, o_variance_valid, o_saturated
//
// The front reads a sample's accumulator from RAM, then writes the update back; o_stall
// is high until that is done, and longer while the queue is full. The back pops a job,
// runs the mean divide, three shift-add multiplies, the variance divide and the
// root, then holds the result on i_stall; a count below two stops after the mean
// divide and a missing channel goes straight to the result. The back sets the rate.
// After reset a clearing pass zeroes the accumulators; o_stall is high during it.
// A two-entry queue lets the front run ahead while a result waits on i_stall.
`timescale 1ns / 1ps
`default_nettype none

module running_mean_variance_stats import rmvs_pkg::*; #(
    parameter int NUM_CHANNELS = NumChannelsDef
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_stall,
    input  wire logic [ChW-1:0]         i_channel,
    input  wire logic signed [SmpW-1:0] i_sample,
    output logic                        o_valid,
    input  wire logic                   i_stall,
    output logic [CntW-1:0]             o_count,
    output logic signed [SmpW-1:0]      o_mean,
    output logic [VarW-1:0]             o_variance,
    output logic [StdW-1:0]             o_std_dev,
    output logic                        o_variance_valid,
    output logic                        o_saturated
);
    t_job push_job, pop_job;
    logic push, full, pop, empty;

    rmvs_front #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_channel (i_channel),
        .i_sample  (i_sample),
        .o_push    (push),
        .o_job     (push_job),
        .i_full    (full)
    );

    rmvs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_job   (pop_job),
        .o_empty (empty)
    );

    rmvs_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_job            (pop_job),
        .i_empty          (empty),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_count          (o_count),
        .o_mean           (o_mean),
        .o_variance       (o_variance),
        .o_std_dev        (o_std_dev),
        .o_variance_valid (o_variance_valid),
        .o_saturated      (o_saturated)
    );

endmodule

`default_nettype wire

### src/rmvs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rmvs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_we,
    input  wire logic [AW-1:0]          i_waddr,
    input  wire logic [WIDTH-1:0]       i_wdata,
    input  wire logic                   i_re,
    input  wire logic [AW-1:0]          i_raddr,
    output logic      [WIDTH-1:0]       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### src/rmvs_front.sv
// Front end: accepts samples, clears and updates the per-channel accumulators.
// Depends on rmvs_pkg and rmvs_ram.
`timescale 1ns / 1ps
`default_nettype none

module rmvs_front import rmvs_pkg::*; #(
    parameter int NUM_CHANNELS = NumChannelsDef
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_stall,
    input  wire logic [ChW-1:0]         i_channel,
    input  wire logic signed [SmpW-1:0] i_sample,
    output logic                        o_push,
    output t_job                        o_job,
    input  wire logic                   i_full
);
    localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [AW-1:0] LastAddr = AW'(NUM_CHANNELS - 1);

    t_front_state r_state, n_state;
    logic [AW-1:0] r_clr_addr;
    logic [AW-1:0] r_addr;
    logic          r_ok;
    logic signed [SmpW-1:0] r_sample;

    logic          accept;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [AccW-1:0] ram_wdata, ram_rdata;

    logic [CntW-1:0]        rd_cnt, cnt_nx;
    logic signed [SumW-1:0] rd_sum, sum_nx;
    logic [SqW-1:0]         rd_sq, sq_nx;
    logic signed [2*SmpW-1:0] smp_sq;
    logic                   sat;

    assign o_stall = (r_state != F_IDLE);
    assign accept  = i_valid && (r_state == F_IDLE);

    // Accumulator update
    assign {rd_cnt, rd_sum, rd_sq} = ram_rdata;
    assign sat    = (rd_cnt == CountMax);
    assign smp_sq = r_sample * r_sample;
    assign cnt_nx = sat ? rd_cnt : rd_cnt + 1'b1;
    assign sum_nx = sat ? rd_sum : rd_sum + SumW'(r_sample);
    assign sq_nx  = sat ? rd_sq  : rd_sq + SqW'($unsigned(smp_sq));

    // Job toward the queue; zero record for a missing channel
    always_comb begin
        o_job.ok    = r_ok;
        o_job.sat   = r_ok && sat;
        o_job.count = r_ok ? cnt_nx : '0;
        o_job.sum   = r_ok ? sum_nx : '0;
        o_job.sumsq = r_ok ? sq_nx  : '0;
    end
    assign o_push = (r_state == F_UPDATE) && !i_full;

    // RAM write: clearing pass or update
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = {cnt_nx, sum_nx, sq_nx};
        if (r_state == F_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else if (o_push && r_ok && !sat) begin
            ram_we = 1'b1;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            F_CLEAR:  if (r_clr_addr == LastAddr) n_state = F_IDLE;
            F_IDLE:   if (accept) n_state = F_UPDATE;
            F_UPDATE: if (!i_full) n_state = F_IDLE;
            default:  n_state = F_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= F_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == F_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    // Captured transfer
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_addr   <= AW'(i_channel);
            r_ok     <= (32'(i_channel) < NUM_CHANNELS);
            r_sample <= i_sample;
        end
    end

    rmvs_ram #(
        .WIDTH (AccW),
        .DEPTH (NUM_CHANNELS)
    ) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (AW'(i_channel)),
        .o_rdata (ram_rdata)
    );

endmodule

`default_nettype wire

### src/rmvs_fifo.sv
// Short job queue between the front end and the back end.
// Depends on rmvs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rmvs_fifo import rmvs_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_full,
    input  wire logic i_pop,
    output t_job      o_job,
    output logic      o_empty
);
    localparam int QAW = (QDepth > 1) ? $clog2(QDepth) : 1;
    localparam logic [QAW:0]   Full = (QAW+1)'(QDepth);
    localparam logic [QAW-1:0] Last = QAW'(QDepth - 1);

    t_job           r_mem [QDepth];
    logic [QAW-1:0] r_wptr, r_rptr;
    logic [QAW:0]   r_cnt;

    assign o_full  = (r_cnt == Full);
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) r_wptr <= (r_wptr == Last) ? '0 : r_wptr + 1'b1;
            if (i_pop)  r_rptr <= (r_rptr == Last) ? '0 : r_rptr + 1'b1;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (i_pop && !i_push) r_cnt <= r_cnt - 1'b1;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full)) else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty)) else $error("queue pop while empty");

endmodule

`default_nettype wire

### src/rmvs_back.sv
// Back end: mean, variance and standard deviation from one accumulator snapshot.
// Shift-add multiplier, restoring divider and bitwise root, one bit per cycle.
// Depends on rmvs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rmvs_back import rmvs_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_job               i_job,
    input  wire logic               i_empty,
    output logic                    o_pop,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [CntW-1:0]         o_count,
    output logic signed [SmpW-1:0]  o_mean,
    output logic [VarW-1:0]         o_variance,
    output logic [StdW-1:0]         o_std_dev,
    output logic                    o_variance_valid,
    output logic                    o_saturated
);
    t_back_state r_state;
    logic [StepW-1:0] r_cnt;

    // Job operands
    logic [CntW-1:0]  r_n;
    logic [SumW-1:0]  r_mag;
    logic             r_neg;
    logic [SqW-1:0]   r_sumsq;

    // Multiplier
    logic [ProdW-1:0] r_ma, r_prod, prod_nx;
    logic [SumW-1:0]  r_mb;
    logic [ProdW-1:0] r_a, r_b;

    // Divider
    logic [ProdW-1:0] r_dnum;
    logic [DivW-1:0]  r_rem;
    logic [DivW:0]    rem_sh, rem_nx;
    logic [DivW-1:0]  r_dd;
    logic [VarW:0]    r_q, q_nx;
    logic             r_over, over_nx, div_ge;

    // Square root
    logic [VarW-1:0]  r_x, r_res, r_bit, res_nx;
    logic [VarW:0]    rb;
    logic             sq_ge;

    logic [SumW-1:0]  job_mag;
    logic             last;

    assign job_mag = i_job.sum[SumW-1] ? SumW'(-i_job.sum) : SumW'(i_job.sum);
    assign last    = (r_cnt == StepW'(1));
    assign o_pop   = (r_state == B_IDLE) && !i_empty;
    assign o_valid = (r_state == B_DONE);

    // One shift-add step
    assign prod_nx = r_prod + (r_mb[0] ? r_ma : '0);

    // One restoring-division step
    assign rem_sh  = {r_rem, r_dnum[ProdW-1]};
    assign div_ge  = (rem_sh >= {1'b0, r_dd});
    assign rem_nx  = div_ge ? rem_sh - {1'b0, r_dd} : rem_sh;
    assign q_nx    = {r_q[VarW-1:0], div_ge};
    assign over_nx = r_over | r_q[VarW];

    // One square-root step
    assign rb     = {1'b0, r_res} + {1'b0, r_bit};
    assign sq_ge  = ({1'b0, r_x} >= rb);
    assign res_nx = sq_ge ? (r_res >> 1) + r_bit : (r_res >> 1);

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            case (r_state)
                B_IDLE: if (!i_empty) r_state <= i_job.ok ? B_DIVM : B_DONE;
                B_DIVM: if (last) r_state <= (r_n < CntW'(2)) ? B_DONE : B_MULA;
                B_MULA: if (last) r_state <= B_MULB;
                B_MULB: if (last) r_state <= B_MULD;
                B_MULD: if (last) r_state <= B_DIVV;
                B_DIVV: if (last) r_state <= B_SQRT;
                B_SQRT: if (last) r_state <= B_DONE;
                B_DONE: if (!i_stall) r_state <= B_IDLE;
                default: r_state <= B_IDLE;
            endcase
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                r_n              <= i_job.count;
                r_mag            <= job_mag;
                r_neg            <= i_job.sum[SumW-1];
                r_sumsq          <= i_job.sumsq;
                o_count          <= i_job.count;
                o_saturated      <= i_job.sat;
                o_mean           <= '0;
                o_variance       <= '0;
                o_std_dev        <= '0;
                o_variance_valid <= i_job.ok && (i_job.count >= CntW'(2));
                r_dnum           <= {job_mag, (ProdW-SumW)'(0)};
                r_rem            <= '0;
                r_q              <= '0;
                r_over           <= 1'b0;
                r_dd             <= DivW'(i_job.count);
                r_cnt            <= StepW'(SumW);
            end
            B_DIVM: begin
                r_dnum <= r_dnum << 1;
                r_rem  <= rem_nx[DivW-1:0];
                r_q    <= q_nx;
                r_cnt  <= r_cnt - 1'b1;
                if (last) begin
                    o_mean <= r_neg ? -$signed(q_nx[SmpW-1:0]) : $signed(q_nx[SmpW-1:0]);
                    r_ma   <= ProdW'(r_sumsq);
                    r_mb   <= SumW'(r_n);
                    r_prod <= '0;
                    r_cnt  <= StepW'(CntW);
                end
            end
            B_MULA, B_MULB, B_MULD: begin
                r_prod <= prod_nx;
                r_ma   <= r_ma << 1;
                r_mb   <= r_mb >> 1;
                r_cnt  <= r_cnt - 1'b1;
                if (last) begin
                    r_prod <= '0;
                    if (r_state == B_MULA) begin
                        r_a   <= prod_nx;
                        r_ma  <= ProdW'(r_mag);
                        r_mb  <= r_mag;
                        r_cnt <= StepW'(SumW);
                    end else if (r_state == B_MULB) begin
                        r_b   <= prod_nx;
                        r_ma  <= ProdW'(r_n);
                        r_mb  <= SumW'(r_n - 1'b1);
                        r_cnt <= StepW'(CntW);
                    end else begin
                        // n*(n-1) divisor, clamped numerator n*sumsq - sum^2
                        r_dd   <= prod_nx[DivW-1:0];
                        r_dnum <= (r_a >= r_b) ? r_a - r_b : '0;
                        r_rem  <= '0;
                        r_q    <= '0;
                        r_over <= 1'b0;
                        r_cnt  <= StepW'(ProdW);
                    end
                end
            end
            B_DIVV: begin
                r_dnum <= r_dnum << 1;
                r_rem  <= rem_nx[DivW-1:0];
                r_q    <= q_nx;
                r_over <= over_nx;
                r_cnt  <= r_cnt - 1'b1;
                if (last) begin
                    o_variance <= (over_nx || q_nx[VarW]) ? '1 : q_nx[VarW-1:0];
                    r_x        <= (over_nx || q_nx[VarW]) ? '1 : q_nx[VarW-1:0];
                    r_res      <= '0;
                    r_bit      <= VarW'(1) << (VarW - 2);
                    r_cnt      <= StepW'(VarW / 2);
                end
            end
            B_SQRT: begin
                if (sq_ge) r_x <= r_x - rb[VarW-1:0];
                r_res <= res_nx;
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt - 1'b1;
                if (last) o_std_dev <= res_nx[StdW-1:0];
            end
            default: ;
        endcase
    end

    a_vv_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_variance_valid |-> o_count >= CntW'(2))
        else $error("variance marked valid with fewer than two samples");
    a_sat_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturated |-> o_count == CountMax)
        else $error("saturated flag without a full count");
    a_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (VarW'(o_std_dev) * VarW'(o_std_dev)) <= o_variance)
        else $error("standard deviation squared exceeds variance");

endmodule

`default_nettype wire
